/* rtl/aev_pkg.sv */
// aev_pkg: shared types, fixed-point constants and the cordic arctangent table
// for the e-terms of annual aberration pipeline; no dependencies
package aev_pkg;

  localparam int EPOCH_W = 44;
  localparam int TERM_W  = 45;
  localparam int CORDIC_STAGES = 48;
  localparam int SHIFT_W = $clog2(CORDIC_STAGES);
  localparam int MUL_LAT = 5;
  localparam int RED_LAT = 4;

  typedef logic [EPOCH_W-1:0] epoch_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [63:0] fix_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } cell_t;

  // product shifts for the rounding multiplier
  localparam logic [6:0] SH_JC  = 7'd54;
  localparam logic [6:0] SH_Q40 = 7'd40;
  localparam logic [6:0] SH_Q60 = 7'd60;
  localparam logic [6:0] SH_Q80 = 7'd80;

  localparam fix_t B1950_Q32    = fix_t'(64'd1950 << 32);
  localparam fix_t JC_SCALE_Q62 = 64'sd46117845195674061;
  localparam fix_t ECC0_Q60     = 64'sd19288503593438057;
  localparam fix_t ECC1_Q60     = 64'sd48341998688165;
  localparam fix_t ECC2_Q60     = 64'sd145268109580;
  localparam fix_t OBL0_Q40     = 64'sd92804098622526325;
  localparam fix_t OBL1_Q40     = 64'sd51511570005492;
  localparam fix_t OBL2_Q40     = 64'sd3507442093;
  localparam fix_t OBL3_Q40     = 64'sd1990116046;
  localparam fix_t PER0_Q40     = 64'sd1116543009014180479;
  localparam fix_t PER1_Q40     = 64'sd6806713648724050;
  localparam fix_t PER2_Q40     = 64'sd1814194185830;
  localparam fix_t PER3_Q40     = 64'sd13194139533;
  localparam fix_t ABER_Q60     = 64'sd114600357303637;
  localparam fix_t ARCSEC_Q80   = 64'sd5861037767974450427;
  localparam fix_t GAIN_Q60     = 64'sd700114967507363238;

  localparam fix_t TURN_Q40    = fix_t'(64'd1296000 << 40);
  localparam fix_t HALF_Q40    = fix_t'(64'd648000 << 40);
  localparam fix_t QUARTER_Q40 = fix_t'(64'd324000 << 40);
  localparam fix_t THREEQ_Q40  = fix_t'(64'd972000 << 40);

  // a full turn is RED_DIV * 2^RED_SH in q40 arcsec
  localparam int RED_SH    = 47;
  localparam int RED_DIV   = 10125;
  localparam int RED_BIAS  = 7 * RED_DIV;
  localparam logic [63:0] RED_RECIP = ((64'd1 << 32) + 64'(RED_DIV) - 64'd1) / 64'(RED_DIV);

  localparam logic [63:0] ONE64 = 64'd1;

  typedef fix_t atan_tab_t [CORDIC_STAGES];

  // series atan(2^-i) in q60, stage zero is atan(1), the eighth turn start step
  function automatic fix_t atan_entry(int i);
    fix_t acc;
    logic [127:0] p;
    acc = '0;
    p = '0;
    if (i == 0) begin
      p = 128'(162000) * 128'(ARCSEC_Q80) + (128'd1 << 19);
      acc = fix_t'(p >> 20);
    end else begin
      if (i * 1 <= 60) acc = acc + $signed((ONE64 << (60 - i * 1)) / 1);
      if (i * 3 <= 60) acc = acc - $signed((ONE64 << (60 - i * 3)) / 3);
      if (i * 5 <= 60) acc = acc + $signed((ONE64 << (60 - i * 5)) / 5);
      if (i * 7 <= 60) acc = acc - $signed((ONE64 << (60 - i * 7)) / 7);
      if (i * 9 <= 60) acc = acc + $signed((ONE64 << (60 - i * 9)) / 9);
      if (i * 11 <= 60) acc = acc - $signed((ONE64 << (60 - i * 11)) / 11);
      if (i * 13 <= 60) acc = acc + $signed((ONE64 << (60 - i * 13)) / 13);
      if (i * 15 <= 60) acc = acc - $signed((ONE64 << (60 - i * 15)) / 15);
      if (i * 17 <= 60) acc = acc + $signed((ONE64 << (60 - i * 17)) / 17);
      if (i * 19 <= 60) acc = acc - $signed((ONE64 << (60 - i * 19)) / 19);
      if (i * 21 <= 60) acc = acc + $signed((ONE64 << (60 - i * 21)) / 21);
      if (i * 23 <= 60) acc = acc - $signed((ONE64 << (60 - i * 23)) / 23);
      if (i * 25 <= 60) acc = acc + $signed((ONE64 << (60 - i * 25)) / 25);
      if (i * 27 <= 60) acc = acc - $signed((ONE64 << (60 - i * 27)) / 27);
      if (i * 29 <= 60) acc = acc + $signed((ONE64 << (60 - i * 29)) / 29);
      if (i * 31 <= 60) acc = acc - $signed((ONE64 << (60 - i * 31)) / 31);
      if (i * 33 <= 60) acc = acc + $signed((ONE64 << (60 - i * 33)) / 33);
      if (i * 35 <= 60) acc = acc - $signed((ONE64 << (60 - i * 35)) / 35);
      if (i * 37 <= 60) acc = acc + $signed((ONE64 << (60 - i * 37)) / 37);
      if (i * 39 <= 60) acc = acc - $signed((ONE64 << (60 - i * 39)) / 39);
      if (i * 41 <= 60) acc = acc + $signed((ONE64 << (60 - i * 41)) / 41);
      if (i * 43 <= 60) acc = acc - $signed((ONE64 << (60 - i * 43)) / 43);
      if (i * 45 <= 60) acc = acc + $signed((ONE64 << (60 - i * 45)) / 45);
      if (i * 47 <= 60) acc = acc - $signed((ONE64 << (60 - i * 47)) / 47);
      if (i * 49 <= 60) acc = acc + $signed((ONE64 << (60 - i * 49)) / 49);
      if (i * 51 <= 60) acc = acc - $signed((ONE64 << (60 - i * 51)) / 51);
      if (i * 53 <= 60) acc = acc + $signed((ONE64 << (60 - i * 53)) / 53);
      if (i * 55 <= 60) acc = acc - $signed((ONE64 << (60 - i * 55)) / 55);
      if (i * 57 <= 60) acc = acc + $signed((ONE64 << (60 - i * 57)) / 57);
      if (i * 59 <= 60) acc = acc - $signed((ONE64 << (60 - i * 59)) / 59);
    end
    return acc;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t t;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      t[i] = atan_entry(i);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

/* rtl/aev_in_if.sv */
// aev_in_if: input channel carrying one epoch item with valid/ready
// depends on aev_pkg
interface aev_in_if import aev_pkg::*; ();
  logic   valid;
  logic   ready;
  epoch_t epoch_fixed;

  modport source (output valid, output epoch_fixed, input ready);
  modport sink (input valid, input epoch_fixed, output ready);
endinterface

/* rtl/aev_out_if.sv */
// aev_out_if: output channel carrying one e-terms vector item with valid/ready
// depends on aev_pkg
interface aev_out_if import aev_pkg::*; ();
  logic  valid;
  logic  ready;
  term_t term_x;
  term_t term_y;
  term_t term_z;

  modport source (output valid, output term_x, output term_y, output term_z, input ready);
  modport sink (input valid, input term_x, input term_y, input term_z, output ready);
endinterface

/* rtl/aev_mul.sv */
// aev_mul: pipelined signed 64x64 multiply with round-half-away shift and
// saturation, built from four 32x32 partial products; depends on aev_pkg
module aev_mul import aev_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_LAT-1:0] en_i,
  input  fix_t               a_i,
  input  fix_t               b_i,
  input  logic [6:0]         shift_i,
  output fix_t               p_o
);

  logic [63:0]  ua_q, ub_q;
  logic [63:0]  pp_q [4];
  logic [127:0] prod_q, rnd_q, sh;
  logic [63:0]  mag;
  logic [MUL_LAT-2:0] neg_q;

  assign sh  = rnd_q >> shift_i;
  assign mag = (|sh[127:63]) ? 64'h7fff_ffff_ffff_ffff : sh[63:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ua_q     <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q     <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_q[0] <= a_i[63] ^ b_i[63];
    end
    if (en_i[1]) begin
      pp_q[0]  <= 64'(ua_q[31:0]) * 64'(ub_q[31:0]);
      pp_q[1]  <= 64'(ua_q[31:0]) * 64'(ub_q[63:32]);
      pp_q[2]  <= 64'(ua_q[63:32]) * 64'(ub_q[31:0]);
      pp_q[3]  <= 64'(ua_q[63:32]) * 64'(ub_q[63:32]);
      neg_q[1] <= neg_q[0];
    end
    if (en_i[2]) begin
      prod_q   <= {64'd0, pp_q[0]} + {32'd0, pp_q[1], 32'd0}
                + {32'd0, pp_q[2], 32'd0} + {pp_q[3], 64'd0};
      neg_q[2] <= neg_q[1];
    end
    if (en_i[3]) begin
      rnd_q    <= prod_q + (128'd1 << (shift_i - 7'd1));
      neg_q[3] <= neg_q[2];
    end
    if (en_i[4]) begin
      p_o <= neg_q[3] ? -fix_t'(mag) : fix_t'(mag);
    end
  end

endmodule

/* rtl/aev_reduce.sv */
// aev_reduce: angle reduction of a q40 arcsec angle into a quarter turn with
// a sign flip flag, four stages; depends on aev_pkg
module aev_reduce import aev_pkg::*; (
  input  logic               clk_i,
  input  logic [RED_LAT-1:0] en_i,
  input  fix_t               ang_i,
  output fix_t               r_o,
  output logic               flip_o
);

  localparam int LOW_W = RED_SH;

  logic signed [18:0] nsum;
  logic [36:0]        qp;
  logic [17:0]        qm, rem;
  logic [63:0]        r0;
  logic [17:0]        n1_q, n2_q;
  logic [3:0]         qt_q;
  logic [13:0]        rem_q;
  logic [LOW_W-1:0]   low1_q, low2_q, low3_q;

  // count of 2^RED_SH units, biased positive by a whole number of turns
  assign nsum = {{2{ang_i[63]}}, ang_i[63:RED_SH]} + 19'(RED_BIAS);
  assign qp   = 37'(n1_q) * 37'(RED_RECIP[18:0]);
  assign qm   = 18'(qt_q) * 18'(RED_DIV);
  assign rem  = n2_q - qm;
  assign r0   = {{(64-14-LOW_W){1'b0}}, rem_q, low3_q};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n1_q   <= nsum[17:0];
      low1_q <= ang_i[LOW_W-1:0];
    end
    if (en_i[1]) begin
      qt_q   <= qp[35:32];
      n2_q   <= n1_q;
      low2_q <= low1_q;
    end
    if (en_i[2]) begin
      rem_q  <= rem[13:0];
      low3_q <= low2_q;
    end
    if (en_i[3]) begin
      if ($signed(r0) <= QUARTER_Q40) begin
        r_o    <= $signed(r0);
        flip_o <= 1'b0;
      end else if ($signed(r0) < THREEQ_Q40) begin
        r_o    <= $signed(r0) - HALF_Q40;
        flip_o <= 1'b1;
      end else begin
        r_o    <= $signed(r0) - TURN_Q40;
        flip_o <= 1'b0;
      end
    end
  end

endmodule

/* rtl/aev_cell.sv */
// aev_cell: one rotation-mode cordic cell, a shift-add step per enabled cycle
// depends on aev_pkg
module aev_cell import aev_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SHIFT_W-1:0] shift_i,
  input  fix_t               atan_i,
  input  cell_t              d_i,
  output cell_t              d_o
);

  fix_t xs, ys;

  assign xs = d_i.x >>> shift_i;
  assign ys = d_i.y >>> shift_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!d_i.z[63]) begin
        d_o.x <= d_i.x - ys;
        d_o.y <= d_i.y + xs;
        d_o.z <= d_i.z - atan_i;
      end else begin
        d_o.x <= d_i.x + ys;
        d_o.y <= d_i.y - xs;
        d_o.z <= d_i.z + atan_i;
      end
    end
  end

endmodule

/* rtl/aberration_eterms_vector.sv */
// aberration_eterms_vector: top level of the e-terms of annual aberration pipeline
// depends on aev_pkg, aev_in_if, aev_out_if, aev_mul, aev_reduce, aev_cell
//
// One Besselian epoch item goes in, one e-terms vector item comes out, one item
// per clock sustained while the output side keeps taking items. The pipeline is
// 93 stages deep; the depth is set by the chain of 64-bit rounding multipliers
// (sixteen units, seven of them in series, five stages each, four 32x32 partial
// products), the angle reduction and the two 48-cell cordic rows that run side
// by side.
// Every stage has its own valid bit and advances when it is empty or its
// successor advances, so a stalled output only holds the stages that are full
// and bubbles close up while the input keeps being taken.
module aberration_eterms_vector import aev_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  aev_in_if.sink       in_i,
  aev_out_if.source    out_o
);

  // stage map
  localparam int S_D  = 0;                       // epoch minus b1950
  localparam int S_JC = S_D + 1;                 // julian centuries multiply
  localparam int S_P1 = S_JC + MUL_LAT;          // first horner multiply
  localparam int S_A1 = S_P1 + MUL_LAT;
  localparam int S_P2 = S_A1 + 1;
  localparam int S_A2 = S_P2 + MUL_LAT;
  localparam int S_P3 = S_A2 + 1;
  localparam int S_A3 = S_P3 + MUL_LAT;          // polynomials done
  localparam int S_R  = S_A3 + 1;                // angle reduction
  localparam int S_Z  = S_R + RED_LAT;           // arcsec to radian
  localparam int S_C0 = S_Z + MUL_LAT;           // first cordic cell
  localparam int S_CL = S_C0 + CORDIC_STAGES - 1;
  localparam int S_F  = S_CL + 1;                // quadrant sign fix
  localparam int S_K  = S_F + 1;                 // ek*cos, ek*sin
  localparam int S_L  = S_K + MUL_LAT;           // kc*cos(e0), kc*sin(e0)
  localparam int S_O  = S_L + MUL_LAT;           // saturate, output register
  localparam int N_ST = S_O + 1;

  localparam fix_t TERM_MAX = fix_t'((64'd1 << (TERM_W - 1)) - 64'd1);
  localparam fix_t TERM_MIN = -TERM_MAX - 64'sd1;

  logic [N_ST-1:0] v_q;
  logic [N_ST:0]   en;

  // stall chain: a stage moves when empty or when the next one moves
  always_comb begin
    en[N_ST] = out_o.ready;
    for (int k = N_ST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k + 1];
    end
  end

  assign in_i.ready  = en[S_D];
  assign out_o.valid = v_q[S_O];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < N_ST; k++) begin
        if (en[k]) v_q[k] <= v_q[k - 1];
      end
    end
  end

  // epoch offset and centuries
  fix_t d_q, jc_m;

  always_ff @(posedge clk_i) begin
    if (en[S_D]) d_q <= fix_t'({{(64-EPOCH_W){1'b0}}, in_i.epoch_fixed}) - B1950_Q32;
  end

  aev_mul u_mul_jc (
    .clk_i, .en_i(en[S_JC +: MUL_LAT]), .a_i(d_q), .b_i(JC_SCALE_Q62),
    .shift_i(SH_JC), .p_o(jc_m)
  );

  // centuries travel alongside the horner steps
  fix_t jc_q [S_P1:S_A2];

  always_ff @(posedge clk_i) begin
    if (en[S_P1]) jc_q[S_P1] <= jc_m;
    for (int k = S_P1 + 1; k <= S_A2; k++) begin
      if (en[k]) jc_q[k] <= jc_q[k - 1];
    end
  end

  // horner step 1
  fix_t m1_ecc, m1_obl, m1_per, t1_ecc_q, t1_obl_q, t1_per_q;

  aev_mul u_mul_e1 (
    .clk_i, .en_i(en[S_P1 +: MUL_LAT]), .a_i(ECC2_Q60), .b_i(jc_m),
    .shift_i(SH_Q40), .p_o(m1_ecc)
  );
  aev_mul u_mul_o1 (
    .clk_i, .en_i(en[S_P1 +: MUL_LAT]), .a_i(OBL3_Q40), .b_i(jc_m),
    .shift_i(SH_Q40), .p_o(m1_obl)
  );
  aev_mul u_mul_p1 (
    .clk_i, .en_i(en[S_P1 +: MUL_LAT]), .a_i(PER3_Q40), .b_i(jc_m),
    .shift_i(SH_Q40), .p_o(m1_per)
  );

  always_ff @(posedge clk_i) begin
    if (en[S_A1]) begin
      t1_ecc_q <= ECC1_Q60 + m1_ecc;
      t1_obl_q <= OBL2_Q40 + m1_obl;
      t1_per_q <= PER2_Q40 + m1_per;
    end
  end

  // horner step 2
  fix_t m2_ecc, m2_obl, m2_per, ecc_q, t2_obl_q, t2_per_q;

  aev_mul u_mul_e2 (
    .clk_i, .en_i(en[S_P2 +: MUL_LAT]), .a_i(t1_ecc_q), .b_i(jc_q[S_A1]),
    .shift_i(SH_Q40), .p_o(m2_ecc)
  );
  aev_mul u_mul_o2 (
    .clk_i, .en_i(en[S_P2 +: MUL_LAT]), .a_i(t1_obl_q), .b_i(jc_q[S_A1]),
    .shift_i(SH_Q40), .p_o(m2_obl)
  );
  aev_mul u_mul_p2 (
    .clk_i, .en_i(en[S_P2 +: MUL_LAT]), .a_i(t1_per_q), .b_i(jc_q[S_A1]),
    .shift_i(SH_Q40), .p_o(m2_per)
  );

  always_ff @(posedge clk_i) begin
    if (en[S_A2]) begin
      ecc_q    <= ECC0_Q60 - m2_ecc;
      t2_obl_q <= OBL1_Q40 + m2_obl;
      t2_per_q <= PER1_Q40 + m2_per;
    end
  end

  // horner step 3 and aberration scale ek = e * 20.49552 arcsec
  fix_t ek_m, m3_obl, m3_per, obl_q, per_q;

  aev_mul u_mul_ek (
    .clk_i, .en_i(en[S_P3 +: MUL_LAT]), .a_i(ecc_q), .b_i(ABER_Q60),
    .shift_i(SH_Q40), .p_o(ek_m)
  );
  aev_mul u_mul_o3 (
    .clk_i, .en_i(en[S_P3 +: MUL_LAT]), .a_i(t2_obl_q), .b_i(jc_q[S_A2]),
    .shift_i(SH_Q40), .p_o(m3_obl)
  );
  aev_mul u_mul_p3 (
    .clk_i, .en_i(en[S_P3 +: MUL_LAT]), .a_i(t2_per_q), .b_i(jc_q[S_A2]),
    .shift_i(SH_Q40), .p_o(m3_per)
  );

  always_ff @(posedge clk_i) begin
    if (en[S_A3]) begin
      obl_q <= OBL0_Q40 - m3_obl;
      per_q <= PER0_Q40 + m3_per;
    end
  end

  // ek waits for the sines and cosines
  fix_t ek_q [S_A3:S_F];

  always_ff @(posedge clk_i) begin
    if (en[S_A3]) ek_q[S_A3] <= ek_m;
    for (int k = S_A3 + 1; k <= S_F; k++) begin
      if (en[k]) ek_q[k] <= ek_q[k - 1];
    end
  end

  // reduce both angles to a quarter turn
  fix_t r_obl, r_per;
  logic f_obl, f_per;

  aev_reduce u_red_per (
    .clk_i, .en_i(en[S_R +: RED_LAT]), .ang_i(per_q), .r_o(r_per), .flip_o(f_per)
  );
  aev_reduce u_red_obl (
    .clk_i, .en_i(en[S_R +: RED_LAT]), .ang_i(obl_q), .r_o(r_obl), .flip_o(f_obl)
  );

  // quadrant flags: bit 0 perihelion, bit 1 obliquity
  logic [1:0] flip_q [S_Z:S_CL];

  always_ff @(posedge clk_i) begin
    if (en[S_Z]) flip_q[S_Z] <= {f_obl, f_per};
    for (int k = S_Z + 1; k <= S_CL; k++) begin
      if (en[k]) flip_q[k] <= flip_q[k - 1];
    end
  end

  // arcsec to radian in q60
  fix_t z_per, z_obl;

  aev_mul u_mul_zp (
    .clk_i, .en_i(en[S_Z +: MUL_LAT]), .a_i(r_per), .b_i(ARCSEC_Q80),
    .shift_i(SH_Q60), .p_o(z_per)
  );
  aev_mul u_mul_zo (
    .clk_i, .en_i(en[S_Z +: MUL_LAT]), .a_i(r_obl), .b_i(ARCSEC_Q80),
    .shift_i(SH_Q60), .p_o(z_obl)
  );

  // two cordic rows, one cell per stage
  cell_t cp_c [CORDIC_STAGES+1];
  cell_t co_c [CORDIC_STAGES+1];

  assign cp_c[0] = '{x: GAIN_Q60, y: '0, z: z_per};
  assign co_c[0] = '{x: GAIN_Q60, y: '0, z: z_obl};

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    aev_cell u_cell_per (
      .clk_i, .en_i(en[S_C0 + g]), .shift_i(SHIFT_W'(g)), .atan_i(ATAN_TAB[g]),
      .d_i(cp_c[g]), .d_o(cp_c[g + 1])
    );
    aev_cell u_cell_obl (
      .clk_i, .en_i(en[S_C0 + g]), .shift_i(SHIFT_W'(g)), .atan_i(ATAN_TAB[g]),
      .d_i(co_c[g]), .d_o(co_c[g + 1])
    );
  end

  // undo the half-turn fold
  fix_t cp_q, sp_q;
  fix_t ce_q [S_F:S_L-1];
  fix_t se_q [S_F:S_L-1];

  always_ff @(posedge clk_i) begin
    if (en[S_F]) begin
      cp_q       <= flip_q[S_CL][0] ? -cp_c[CORDIC_STAGES].x : cp_c[CORDIC_STAGES].x;
      sp_q       <= flip_q[S_CL][0] ? -cp_c[CORDIC_STAGES].y : cp_c[CORDIC_STAGES].y;
      ce_q[S_F]  <= flip_q[S_CL][1] ? -co_c[CORDIC_STAGES].x : co_c[CORDIC_STAGES].x;
      se_q[S_F]  <= flip_q[S_CL][1] ? -co_c[CORDIC_STAGES].y : co_c[CORDIC_STAGES].y;
    end
    for (int k = S_F + 1; k < S_L; k++) begin
      if (en[k]) begin
        ce_q[k] <= ce_q[k - 1];
        se_q[k] <= se_q[k - 1];
      end
    end
  end

  // kc = ek*cos(pl), x = ek*sin(pl)
  fix_t kc_m, xm_m;

  aev_mul u_mul_kc (
    .clk_i, .en_i(en[S_K +: MUL_LAT]), .a_i(ek_q[S_F]), .b_i(cp_q),
    .shift_i(SH_Q60), .p_o(kc_m)
  );
  aev_mul u_mul_x (
    .clk_i, .en_i(en[S_K +: MUL_LAT]), .a_i(ek_q[S_F]), .b_i(sp_q),
    .shift_i(SH_Q80), .p_o(xm_m)
  );

  fix_t xm_q [S_L:S_O-1];

  always_ff @(posedge clk_i) begin
    if (en[S_L]) xm_q[S_L] <= xm_m;
    for (int k = S_L + 1; k < S_O; k++) begin
      if (en[k]) xm_q[k] <= xm_q[k - 1];
    end
  end

  // y and z from the obliquity rotation
  fix_t ym_m, zm_m;

  aev_mul u_mul_y (
    .clk_i, .en_i(en[S_L +: MUL_LAT]), .a_i(kc_m), .b_i(ce_q[S_L-1]),
    .shift_i(SH_Q80), .p_o(ym_m)
  );
  aev_mul u_mul_z (
    .clk_i, .en_i(en[S_L +: MUL_LAT]), .a_i(kc_m), .b_i(se_q[S_L-1]),
    .shift_i(SH_Q80), .p_o(zm_m)
  );

  // clamp to the output range
  function automatic term_t pack(fix_t v);
    if (v > TERM_MAX) return TERM_MAX[TERM_W-1:0];
    if (v < TERM_MIN) return TERM_MIN[TERM_W-1:0];
    return v[TERM_W-1:0];
  endfunction

  term_t tx_q, ty_q, tz_q;

  always_ff @(posedge clk_i) begin
    if (en[S_O]) begin
      tx_q <= pack(xm_q[S_O-1]);
      ty_q <= pack(-ym_m);
      tz_q <= pack(-zm_m);
    end
  end

  assign out_o.term_x = tx_q;
  assign out_o.term_y = ty_q;
  assign out_o.term_z = tz_q;

endmodule
